/* rtl/smx_pkg.sv */
package smx_pkg;

   // Sizes
   localparam int STACK_DEPTH   = 1024;
   localparam int SA_W          = $clog2(STACK_DEPTH);
   localparam int SP_W          = SA_W + 1;
   localparam int DATA_WORDS    = 1024;
   localparam int DA_W          = $clog2(DATA_WORDS);
   localparam int DC_W          = DA_W + 1;
   localparam int PROGRAM_BYTES = 4096;
   localparam int PC_W          = 13;
   localparam int DATA_W        = 32;
   localparam int KIND_W        = 5;
   localparam int LIT_W         = 31;
   localparam int DIG_W         = 4;
   localparam int FAULT_W       = 3;

   // Opcodes
   localparam logic [KIND_W-1:0] K_RET    = 5'd0;
   localparam logic [KIND_W-1:0] K_SUB    = 5'd1;
   localparam logic [KIND_W-1:0] K_ADD    = 5'd2;
   localparam logic [KIND_W-1:0] K_MUL    = 5'd3;
   localparam logic [KIND_W-1:0] K_DIV    = 5'd4;
   localparam logic [KIND_W-1:0] K_MOD    = 5'd5;
   localparam logic [KIND_W-1:0] K_JNEG   = 5'd6;
   localparam logic [KIND_W-1:0] K_JPOS   = 5'd7;
   localparam logic [KIND_W-1:0] K_JZERO  = 5'd8;
   localparam logic [KIND_W-1:0] K_JEMPTY = 5'd9;
   localparam logic [KIND_W-1:0] K_CALL   = 5'd10;
   localparam logic [KIND_W-1:0] K_DUP    = 5'd11;
   localparam logic [KIND_W-1:0] K_LOAD   = 5'd12;
   localparam logic [KIND_W-1:0] K_DROP   = 5'd13;
   localparam logic [KIND_W-1:0] K_STORE  = 5'd14;
   localparam logic [KIND_W-1:0] K_SWAP   = 5'd15;
   localparam logic [KIND_W-1:0] K_LIT    = 5'd16;

   // Fault codes
   localparam logic [FAULT_W-1:0] FLT_NONE  = 3'd0;
   localparam logic [FAULT_W-1:0] FLT_UNDER = 3'd1;
   localparam logic [FAULT_W-1:0] FLT_OVER  = 3'd2;
   localparam logic [FAULT_W-1:0] FLT_DIV0  = 3'd3;
   localparam logic [FAULT_W-1:0] FLT_ADDR  = 3'd4;

   // Source of the new top of stack
   localparam logic [2:0] SRC_KEEP   = 3'd0;
   localparam logic [2:0] SRC_ALU    = 3'd1;
   localparam logic [2:0] SRC_DIV    = 3'd2;
   localparam logic [2:0] SRC_DMEM   = 3'd3;
   localparam logic [2:0] SRC_REFILL = 3'd4;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic eval;
      logic div_start;
      logic commit;
      logic refill;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_go;
      logic div_done;
      logic refill_go;
   } status_type;

endpackage

/* rtl/smx_div.sv */
module smx_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [smx_pkg::DATA_W-1:0] dividend,
   input  logic [smx_pkg::DATA_W-1:0] divisor,
   output logic                       done,
   output logic [smx_pkg::DATA_W-1:0] quotient,
   output logic [smx_pkg::DATA_W-1:0] remainder
);
   import smx_pkg::*;

   localparam int CNT_W = $clog2(DATA_W) + 1;

   logic [DATA_W:0]   rem_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [DATA_W-1:0] dvs_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic              negq_ff;
   logic              negr_ff;
   logic [DATA_W:0]   shifted;
   logic [DATA_W+1:0] diff;

   // one restoring step per cycle
   assign shifted = {rem_ff[DATA_W-1:0], quo_ff[DATA_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(DATA_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quo_ff  <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
         dvs_ff  <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
         negq_ff <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
         negr_ff <= dividend[DATA_W-1];
      end else if (cnt_ff != '0) begin
         rem_ff <= diff[DATA_W+1] ? shifted : diff[DATA_W:0];
         quo_ff <= {quo_ff[DATA_W-2:0], ~diff[DATA_W+1]};
      end
   end

   // sign fix: quotient truncates, remainder follows the dividend
   assign done      = done_ff;
   assign quotient  = negq_ff ? (~quo_ff + DATA_W'(1)) : quo_ff;
   assign remainder = negr_ff ? (~rem_ff[DATA_W-1:0] + DATA_W'(1)) : rem_ff[DATA_W-1:0];

endmodule

/* rtl/smx_dpath.sv */
module smx_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  smx_pkg::cmd_type                   cmd,
   output smx_pkg::status_type                status,
   input  logic        [smx_pkg::KIND_W-1:0]  req_kind,
   input  logic        [smx_pkg::LIT_W-1:0]   req_literal_value,
   input  logic        [smx_pkg::DIG_W-1:0]   req_literal_digits,
   output logic signed [smx_pkg::PC_W-1:0]    rsp_next_pc,
   output logic                               rsp_halted,
   output logic signed [smx_pkg::DATA_W-1:0]  rsp_top_value,
   output logic        [smx_pkg::SP_W-1:0]    rsp_depth,
   output logic        [smx_pkg::FAULT_W-1:0] rsp_fault
);
   import smx_pkg::*;

   // memories
   logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
   logic [DATA_W-1:0] dm_mem  [DATA_WORDS];
   logic [DATA_W-1:0] stk_rd_ff;
   logic [DATA_W-1:0] dm_rd_ff;
   logic [SA_W-1:0]   stk_ra;
   logic [SP_W-1:0]   stk_ra_full;

   // architectural state
   logic [SP_W-1:0]   sp_ff;
   logic [PC_W-1:0]   pc_ff;
   logic [DATA_W-1:0] top_ff;
   logic [DC_W-1:0]   clr_ff;

   // latched item
   logic [KIND_W-1:0] kind_ff;
   logic [LIT_W-1:0]  lit_ff;
   logic [DIG_W-1:0]  dig_ff;

   // plan from evaluation
   logic [FAULT_W-1:0] fault_ff, fault_in;
   logic [SP_W-1:0]    newsp_ff, newsp_in;
   logic [PC_W-1:0]    newpc_ff, newpc_in;
   logic [DATA_W-1:0]  alu_ff, alu_in;
   logic [2:0]         src_ff, src_in;
   logic               stk_we_ff, stk_we_in;
   logic [SA_W-1:0]    stk_wa_ff, stk_wa_in;
   logic [DATA_W-1:0]  stk_wd_ff, stk_wd_in;
   logic               dm_we_ff, dm_we_in;
   logic [DA_W-1:0]    dm_wa_ff, dm_wa_in;
   logic [DATA_W-1:0]  dm_wd_ff, dm_wd_in;
   logic               mod_ff;

   // divider
   logic              div_done;
   logic [DATA_W-1:0] div_q;
   logic [DATA_W-1:0] div_r;

   // operands
   logic [DATA_W-1:0] topv;
   logic [DATA_W-1:0] nxt;
   logic              halted;
   logic [1:0]        need;
   logic              jump;
   logic              tgt_ok;
   logic [DIG_W-1:0]  inc;
   logic [PC_W:0]     seq_pc;
   logic              seq_ok;
   logic [SP_W-1:0]   sp_m1;
   logic [SP_W-1:0]   sp_m2;
   logic [DATA_W-1:0] ret_addr;

   assign topv     = (sp_ff != '0) ? top_ff : '0;
   assign nxt      = (sp_ff >= SP_W'(2)) ? stk_rd_ff : '0;
   assign halted   = (pc_ff == '1);
   assign sp_m1    = sp_ff - SP_W'(1);
   assign sp_m2    = sp_ff - SP_W'(2);
   assign ret_addr = DATA_W'(pc_ff) + DATA_W'(1);
   assign tgt_ok   = (topv == '1) || (topv < DATA_W'(PROGRAM_BYTES));

   // evaluation of one instruction
   always_comb begin
      fault_in  = FLT_NONE;
      newsp_in  = sp_ff;
      newpc_in  = pc_ff;
      alu_in    = topv;
      src_in    = SRC_KEEP;
      stk_we_in = 1'b0;
      stk_wa_in = sp_m1[SA_W-1:0];
      stk_wd_in = topv;
      dm_we_in  = 1'b0;
      dm_wa_in  = topv[DA_W-1:0];
      dm_wd_in  = nxt;
      jump      = 1'b0;
      inc       = DIG_W'(1);
      need      = 2'd0;
      unique case (kind_ff) inside
         K_RET, K_JEMPTY, K_CALL, K_DUP, K_LOAD, K_DROP: need = 2'd1;
         K_SUB, K_ADD, K_MUL, K_DIV, K_MOD, K_JNEG, K_JPOS, K_JZERO,
         K_STORE, K_SWAP: need = 2'd2;
         default: need = 2'd0;
      endcase
      if (!halted) begin
         if (sp_ff < SP_W'(need)) begin
            fault_in = FLT_UNDER;
         end else begin
            unique case (kind_ff) inside
               K_RET: begin
                  newsp_in = sp_m1;
                  jump     = 1'b1;
                  src_in   = SRC_REFILL;
               end
               K_SUB, K_ADD, K_MUL: begin
                  newsp_in = sp_m1;
                  src_in   = SRC_ALU;
                  if (kind_ff == K_SUB)      alu_in = topv - nxt;
                  else if (kind_ff == K_ADD) alu_in = topv + nxt;
                  else                       alu_in = topv * nxt;
               end
               K_DIV, K_MOD: begin
                  if (nxt == '0) begin
                     fault_in = FLT_DIV0;
                  end else begin
                     newsp_in = sp_m1;
                     src_in   = SRC_DIV;
                  end
               end
               K_JNEG, K_JPOS, K_JZERO: begin
                  newsp_in = sp_m2;
                  src_in   = SRC_REFILL;
                  if (kind_ff == K_JNEG)      jump = nxt[DATA_W-1];
                  else if (kind_ff == K_JPOS) jump = !nxt[DATA_W-1] && (nxt != '0);
                  else                        jump = (nxt == '0);
               end
               K_JEMPTY: begin
                  newsp_in = sp_m1;
                  src_in   = SRC_REFILL;
                  jump     = (sp_m1 == '0);
               end
               K_CALL: begin
                  alu_in = ret_addr;
                  src_in = SRC_ALU;
                  jump   = 1'b1;
               end
               K_DUP: begin
                  if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                     fault_in = FLT_OVER;
                  end else begin
                     stk_we_in = 1'b1;
                     newsp_in  = sp_ff + SP_W'(1);
                     src_in    = SRC_ALU;
                  end
               end
               K_LOAD: begin
                  if (topv >= DATA_W'(DATA_WORDS)) fault_in = FLT_ADDR;
                  else                             src_in   = SRC_DMEM;
               end
               K_DROP: begin
                  newsp_in = sp_m1;
                  src_in   = SRC_REFILL;
               end
               K_STORE: begin
                  if (topv >= DATA_W'(DATA_WORDS)) begin
                     fault_in = FLT_ADDR;
                  end else begin
                     dm_we_in = 1'b1;
                     newsp_in = sp_m2;
                     src_in   = SRC_REFILL;
                  end
               end
               K_SWAP: begin
                  stk_we_in = 1'b1;
                  stk_wa_in = sp_m2[SA_W-1:0];
                  alu_in    = nxt;
                  src_in    = SRC_ALU;
               end
               K_LIT: begin
                  if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                     fault_in = FLT_OVER;
                  end else begin
                     stk_we_in = (sp_ff != '0);
                     newsp_in  = sp_ff + SP_W'(1);
                     alu_in    = DATA_W'(lit_ff);
                     src_in    = SRC_ALU;
                     inc       = dig_ff;
                  end
               end
               default: ;
            endcase
         end
      end
      // new program counter and its range check
      seq_pc = {1'b0, pc_ff} + (PC_W+1)'(inc);
      seq_ok = seq_pc < (PC_W+1)'(PROGRAM_BYTES);
      if (!halted && fault_in == FLT_NONE) begin
         if (jump) begin
            newpc_in = topv[PC_W-1:0];
            if (!tgt_ok) fault_in = FLT_ADDR;
         end else begin
            newpc_in = seq_pc[PC_W-1:0];
            if (!seq_ok) fault_in = FLT_ADDR;
         end
      end
   end

   // item latch and plan registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         lit_ff  <= req_literal_value;
         dig_ff  <= req_literal_digits;
      end
      if (cmd.eval) begin
         fault_ff  <= fault_in;
         newsp_ff  <= newsp_in;
         newpc_ff  <= newpc_in;
         alu_ff    <= alu_in;
         src_ff    <= src_in;
         stk_we_ff <= stk_we_in && (fault_in == FLT_NONE);
         stk_wa_ff <= stk_wa_in;
         stk_wd_ff <= stk_wd_in;
         dm_we_ff  <= dm_we_in && (fault_in == FLT_NONE);
         dm_wa_ff  <= dm_wa_in;
         dm_wd_ff  <= dm_wd_in;
         mod_ff    <= (kind_ff == K_MOD);
      end
   end

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= '0;
         pc_ff  <= '0;
         clr_ff <= '0;
      end else begin
         if (cmd.clear_en) clr_ff <= clr_ff + DC_W'(1);
         if (cmd.commit && fault_ff == FLT_NONE) begin
            sp_ff <= newsp_ff;
            pc_ff <= newpc_ff;
         end
      end
   end

   // top of stack register
   always_ff @(posedge clock) begin
      if (cmd.commit && fault_ff == FLT_NONE) begin
         case (src_ff)
            SRC_ALU:  top_ff <= alu_ff;
            SRC_DIV:  top_ff <= mod_ff ? div_r : div_q;
            SRC_DMEM: top_ff <= dm_rd_ff;
            default:  ;
         endcase
      end else if (cmd.refill) begin
         top_ff <= stk_rd_ff;
      end
   end

   // stack memory: entries below the top
   assign stk_ra_full = cmd.commit ? (newsp_ff - SP_W'(1)) : sp_m2;
   assign stk_ra      = stk_ra_full[SA_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.commit && stk_we_ff && fault_ff == FLT_NONE) stk_mem[stk_wa_ff] <= stk_wd_ff;
      stk_rd_ff <= stk_mem[stk_ra];
   end

   // data memory with clearing pass
   always_ff @(posedge clock) begin
      if (cmd.clear_en)
         dm_mem[clr_ff[DA_W-1:0]] <= '0;
      else if (cmd.commit && dm_we_ff && fault_ff == FLT_NONE)
         dm_mem[dm_wa_ff] <= dm_wd_ff;
      dm_rd_ff <= dm_mem[topv[DA_W-1:0]];
   end

   smx_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (topv),
      .divisor   (nxt),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_next_pc   <= pc_ff;
         rsp_halted    <= halted;
         rsp_top_value <= topv;
         rsp_depth     <= sp_ff;
         rsp_fault     <= fault_ff;
      end
   end

   // status to controller
   always_comb begin
      status.clear_last = (clr_ff == DC_W'(DATA_WORDS - 1));
      status.div_go     = (src_in == SRC_DIV) && (fault_in == FLT_NONE);
      status.div_done   = div_done;
      status.refill_go  = (src_ff == SRC_REFILL) && (fault_ff == FLT_NONE)
                          && (newsp_ff != '0);
   end

endmodule

/* rtl/smx_ctrl.sv */
module smx_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  smx_pkg::status_type status,
   output smx_pkg::cmd_type    cmd
);
   import smx_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EVAL   = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;
   localparam logic [2:0] S_REFILL = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (status.div_go) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_DIV: begin
            if (status.div_done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = status.refill_go ? S_REFILL : S_DONE;
         end
         S_REFILL: begin
            cmd.refill = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/stack_machine_execute.sv */
// Execute stage of a zero-operand stack machine.
// Input channel (req_): one decoded instruction per item: opcode, and for a
// literal its value and the number of program digits it occupies.
// Result channel (rsp_): one item per instruction with the program counter
// after it, the halted flag, top of stack (zero when empty), stack depth and
// a fault code. A faulting instruction leaves all state unchanged.
// Sequence: an accepted item goes through eval, commit and done; a pop that
// has to refetch the new top of stack through the single read port of the
// stack RAM adds a refill state after commit; div and mod wait in a divide
// state for the bit-serial divider. One item is in flight at a time: a new
// item is accepted only after the last result is loaded for output.
// Reset: program counter and stack pointer clear, then a clearing pass
// zeroes all words of the data memory, one word a cycle; req_ready stays
// low until it ends.
// Stall: the result waits in an output register; the next item is still
// accepted and executed, and only its result waits until rsp_ready frees
// the register.
module stack_machine_execute (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic        [smx_pkg::KIND_W-1:0]  req_kind,
   input  logic        [smx_pkg::LIT_W-1:0]   req_literal_value,
   input  logic        [smx_pkg::DIG_W-1:0]   req_literal_digits,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [smx_pkg::PC_W-1:0]    rsp_next_pc,
   output logic                               rsp_halted,
   output logic signed [smx_pkg::DATA_W-1:0]  rsp_top_value,
   output logic        [smx_pkg::SP_W-1:0]    rsp_depth,
   output logic        [smx_pkg::FAULT_W-1:0] rsp_fault
);
   import smx_pkg::*;

   cmd_type    cmd;
   status_type status;

   smx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   smx_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_kind),
      .req_literal_value  (req_literal_value),
      .req_literal_digits (req_literal_digits),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_halted         (rsp_halted),
      .rsp_top_value      (rsp_top_value),
      .rsp_depth          (rsp_depth),
      .rsp_fault          (rsp_fault)
   );

endmodule
